>>> design/kdt_pkg.sv
// ----------------------------------------------------------------------------
// kdt_pkg - shared types and constants
// Widths, key bit positions and control structs for the key panel.
// ----------------------------------------------------------------------------
package kdt_pkg;

    localparam int KEY_CHANNELS = 4;
    localparam int CNT_W        = 8;
    localparam int REMOTE_KEYS  = 2;  // keys below this index are remote keys

    localparam logic [CNT_W-1:0] COUNT_MAX       = '1;
    localparam logic [CNT_W-1:0] THRESHOLD_RESET = CNT_W'(20);

    // key bit positions
    localparam int KEY_REM_PWR = 0;
    localparam int KEY_REM_SBY = 1;
    localparam int KEY_LOC_PWR = 2;
    localparam int KEY_LOC_SBY = 3;

    typedef logic [KEY_CHANNELS-1:0] t_keys;
    typedef logic [CNT_W-1:0]        t_count;

    // processing strobe for one word
    typedef struct packed {
        logic fire;  // word leaves the input register this cycle
        logic tick;  // word carries a scan tick
    } t_scan_ctl;

endpackage

>>> design/kdt_if.sv
// ----------------------------------------------------------------------------
// kdt_in_if / kdt_out_if - key panel channels
// Valid/ready channels for pin words in and panel status words out.
// ----------------------------------------------------------------------------
interface kdt_in_if;
    logic            valid;
    logic            ready;
    kdt_pkg::t_keys  key_pins_n;
    logic            scan_tick;

    modport source (output valid, output key_pins_n, output scan_tick, input ready);
    modport sink   (input valid, input key_pins_n, input scan_tick, output ready);
endinterface

interface kdt_out_if;
    logic            valid;
    logic            ready;
    kdt_pkg::t_keys  debounced_keys;
    logic            remote_power_on;
    logic            remote_standby_on;
    logic            local_power_on;
    logic            local_standby_on;
    logic            remote_mode;

    modport source (output valid, output debounced_keys, output remote_power_on,
                    output remote_standby_on, output local_power_on,
                    output local_standby_on, output remote_mode, input ready);
    modport sink   (input valid, input debounced_keys, input remote_power_on,
                    input remote_standby_on, input local_power_on,
                    input local_standby_on, input remote_mode, output ready);
endinterface

>>> design/kdt_debounce.sv
// ----------------------------------------------------------------------------
// kdt_debounce - per-key stability counters
// Saturating counter per key; accepted bit follows the sample once stable.
// ----------------------------------------------------------------------------
module kdt_debounce (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  kdt_pkg::t_scan_ctl i_ctl,
    input  kdt_pkg::t_keys    i_sample,
    input  kdt_pkg::t_count   i_threshold,
    output kdt_pkg::t_keys    o_accepted_next
);
    import kdt_pkg::*;

    t_keys  r_last;
    t_keys  r_accepted;
    t_count r_count [KEY_CHANNELS];

    t_keys  n_last;
    t_keys  n_accepted;
    t_count n_count [KEY_CHANNELS];
    t_count cnt_inc [KEY_CHANNELS];

    always_comb begin
        n_last     = i_ctl.tick ? i_sample : r_last;
        n_accepted = r_accepted;
        for (int ch = 0; ch < KEY_CHANNELS; ch++) begin
            cnt_inc[ch] = (r_count[ch] == COUNT_MAX) ? r_count[ch] : r_count[ch] + t_count'(1);
            n_count[ch] = r_count[ch];
            if (i_ctl.tick) begin
                if (i_sample[ch] != r_last[ch]) begin
                    n_count[ch]    = '0;
                    n_accepted[ch] = 1'b0;
                end else begin
                    n_count[ch] = cnt_inc[ch];
                    if (cnt_inc[ch] >= i_threshold) begin
                        n_accepted[ch] = i_sample[ch];
                    end
                end
            end
        end
    end

    assign o_accepted_next = n_accepted;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last     <= '0;
            r_accepted <= '0;
            for (int ch = 0; ch < KEY_CHANNELS; ch++) begin
                r_count[ch] <= '0;
            end
        end else if (i_ctl.fire) begin
            r_last     <= n_last;
            r_accepted <= n_accepted;
            for (int ch = 0; ch < KEY_CHANNELS; ch++) begin
                r_count[ch] <= n_count[ch];
            end
        end
    end

`ifndef SYNTHESIS
    // an accepted press always matches the last sampled level
    a_accepted_matches_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_accepted & ~r_last) == '0)
        else $error("accepted key without pressed sample");
`endif

endmodule

>>> design/kdt_keys.sv
// ----------------------------------------------------------------------------
// kdt_keys - press edge handling and toggle flags
// Toggles a flag on each new accepted press, picks remote/local mode and
// clears the unselected side's flags where the selected side is on.
// ----------------------------------------------------------------------------
module kdt_keys (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_fire,
    input  kdt_pkg::t_keys i_accepted,
    output kdt_pkg::t_keys o_flags_next,
    output logic           o_remote_next
);
    import kdt_pkg::*;

    t_keys r_handled;
    t_keys r_flags;
    logic  r_remote;

    t_keys n_handled;
    t_keys n_toggled;
    t_keys n_flags;
    logic  n_remote;

    always_comb begin
        n_handled = r_handled;
        n_toggled = r_flags;
        n_remote  = r_remote;
        // bit order matters: the last new press decides the mode
        for (int k = 0; k < KEY_CHANNELS; k++) begin
            if (i_accepted[k] && !r_handled[k]) begin
                n_handled[k] = 1'b1;
                n_remote     = (k < REMOTE_KEYS);
                n_toggled[k] = ~r_flags[k];
            end else if (!i_accepted[k]) begin
                n_handled[k] = 1'b0;
            end
        end

        n_flags = n_toggled;
        if (n_remote) begin
            if (n_toggled[KEY_REM_PWR]) n_flags[KEY_LOC_PWR] = 1'b0;
            if (n_toggled[KEY_REM_SBY]) n_flags[KEY_LOC_SBY] = 1'b0;
        end else begin
            if (n_toggled[KEY_LOC_PWR]) n_flags[KEY_REM_PWR] = 1'b0;
            if (n_toggled[KEY_LOC_SBY]) n_flags[KEY_REM_SBY] = 1'b0;
        end
    end

    assign o_flags_next  = n_flags;
    assign o_remote_next = n_remote;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_handled <= '0;
            r_flags   <= '0;
            r_remote  <= 1'b0;
        end else if (i_fire) begin
            r_handled <= n_handled;
            r_flags   <= n_flags;
            r_remote  <= n_remote;
        end
    end

`ifndef SYNTHESIS
    // remote and local flag of the same function are never both on
    a_sides_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_flags[KEY_REM_PWR] && r_flags[KEY_LOC_PWR]) &&
        !(r_flags[KEY_REM_SBY] && r_flags[KEY_LOC_SBY]))
        else $error("remote and local flags both set");
`endif

endmodule

>>> design/key_debounce_toggle_panel_unit.sv
// ----------------------------------------------------------------------------
// key_debounce_toggle_panel_unit - debounced four-key toggle panel
// Debounces active-low key pins and keeps power/standby toggle flags.
// ----------------------------------------------------------------------------
// Usage:
//   i_item   : valid/ready channel, one word per key scan: four active-low
//              pins (remote power, remote standby, local power, local
//              standby) and a scan tick. Without a tick the debounce state
//              holds but press handling still runs.
//   o_result : valid/ready channel, exactly one status word per input word:
//              debounced keys, four toggle flags, and remote/local mode.
//   i_cfg_wr_en / i_cfg_wr_data : stable threshold in scan ticks; write it
//              only while the block is idle.
// Flow: a word accepted into the input register passes through the debounce
//   and key logic into the result register. Throughput: one word per cycle
//   while o_result is not stalled, set by the single pass from the input
//   register through the debounce and key logic into the result register.
// Reset (synchronous, active low): all counters, flags and mode clear, the
//   threshold returns to 20, both registers empty.
// Stall: a held result keeps its word; one more word may wait in the input
//   register, after which i_item.ready drops until o_result is taken.
// ----------------------------------------------------------------------------
module key_debounce_toggle_panel_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  kdt_pkg::t_count      i_cfg_wr_data,
    kdt_in_if.sink               i_item,
    kdt_out_if.source            o_result
);
    import kdt_pkg::*;

    // configuration
    t_count r_threshold;

    // input register
    logic   r_in_valid;
    t_keys  r_in_pins_n;
    logic   r_in_tick;

    // result register
    logic   r_res_valid;
    t_keys  r_res_keys;
    t_keys  r_res_flags;
    logic   r_res_remote;

    logic      in_accept;
    logic      advance;
    t_scan_ctl scan_ctl;
    t_keys     accepted_next;
    t_keys     flags_next;
    logic      remote_next;

    // the input word moves on whenever the result slot is free or draining
    assign advance   = r_in_valid && (!r_res_valid || o_result.ready);
    assign in_accept = i_item.valid && i_item.ready;
    assign i_item.ready = !r_in_valid || advance;

    assign scan_ctl.fire = advance;
    assign scan_ctl.tick = r_in_tick;

    kdt_debounce u_debounce (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (scan_ctl),
        .i_sample        (~r_in_pins_n),
        .i_threshold     (r_threshold),
        .o_accepted_next (accepted_next)
    );

    kdt_keys u_keys (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (advance),
        .i_accepted    (accepted_next),
        .o_flags_next  (flags_next),
        .o_remote_next (remote_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RESET;
        end else if (i_cfg_wr_en) begin
            r_threshold <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_pins_n <= i_item.key_pins_n;
            r_in_tick   <= i_item.scan_tick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (advance) begin
            r_res_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res_keys   <= accepted_next;
            r_res_flags  <= flags_next;
            r_res_remote <= remote_next;
        end
    end

    assign o_result.valid             = r_res_valid;
    assign o_result.debounced_keys    = r_res_keys;
    assign o_result.remote_power_on   = r_res_flags[KEY_REM_PWR];
    assign o_result.remote_standby_on = r_res_flags[KEY_REM_SBY];
    assign o_result.local_power_on    = r_res_flags[KEY_LOC_PWR];
    assign o_result.local_standby_on  = r_res_flags[KEY_LOC_SBY];
    assign o_result.remote_mode       = r_res_remote;

`ifndef SYNTHESIS
    // a waiting word with a free result slot always moves on
    a_no_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !r_res_valid) |=> r_res_valid)
        else $error("input word did not advance into free result slot");

    // input stalls only when the input register is occupied
    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_item.ready |-> (r_in_valid && r_res_valid))
        else $error("input stalled while pipeline has room");
`endif

endmodule
